/* sv/rclp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the per-line run tracking function for the
// row/column run-length profiler. No dependencies.
package rclp_pkg;

    localparam int DEF_MAX_SIDE = 128;
    localparam logic [7:0] GRID_SIZE_RESET = 8'd128;
    localparam logic [7:0] RUN_MAX = 8'hFF;

    // Output queue geometry; one item can push up to RES_PER_ITEM results.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = 4;
    localparam int RES_PER_ITEM = 4;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] pend;
        logic       pvalid;
    } line_state_t;

    typedef struct packed {
        logic        emit_a;
        logic [7:0]  len_a;
        logic        emit_last;
        logic [7:0]  len_last;
        line_state_t next_st;
    } line_out_t;

    typedef struct packed {
        logic       is_column;
        logic [6:0] line_index;
        logic [7:0] run_length;
        logic       last_in_line;
    } result_t;

    typedef struct packed {
        logic [RES_PER_ITEM-1:0]          valid;
        result_t [RES_PER_ITEM-1:0]       res;
    } push_t;

    // Advances one line by one cell. The held-back run is released when a
    // newer run closes, and the final run is tagged when the line ends.
    function automatic line_out_t line_step(input logic filled, input logic at_end,
                                            input line_state_t cur);
        line_out_t   o;
        line_state_t st;
        logic [7:0]  cnt;
        logic        closes;
        cnt = cur.count;
        if (filled && cnt != RUN_MAX) begin
            cnt = cnt + 8'd1;
        end
        closes = (cnt != 8'd0) && (!filled || at_end);
        o.emit_a = closes && cur.pvalid;
        o.len_a = cur.pend;
        st = cur;
        st.count = cnt;
        if (closes) begin
            st.pend = cnt;
            st.pvalid = 1'b1;
            st.count = 8'd0;
        end
        o.emit_last = at_end;
        o.len_last = st.pvalid ? st.pend : 8'd0;
        if (at_end) begin
            st = '0;
        end
        o.next_st = st;
        return o;
    endfunction

endpackage

/* sv/row_column_run_length_profiler.sv */
`timescale 1ns / 1ps
// Top level of the row/column run-length profiler: position counters, column
// state memory with read-modify-write, and the result queue. Uses rclp_pkg.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_cell_filled
//   m_        out        m_valid / m_ready   m_is_column, m_line_index,
//                                            m_run_length, m_last_in_line
//   cfg_      in         cfg_wr_en           cfg_wr_data (grid size)
//
// One cell is taken per cycle while s_ready is high; the column state is read in
// the accept cycle and written back in the following cycle, with a bypass when
// the same column comes twice in a row. A cell is taken while the result queue
// has room for four more results, so throughput is bounded by one result per
// cycle at the output. After reset a clearing pass zeroes all MAX_SIDE entries
// of the column memory, and s_ready stays low until it is done.
module row_column_run_length_profiler
    import rclp_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cell_filled,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_column,
    output logic [6:0] m_line_index,
    output logic [7:0] m_run_length,
    output logic       m_last_in_line
);

    localparam int POS_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W = (SIDE_W > 8) ? SIDE_W : 8;
    localparam int IDX_W = (POS_W > 7) ? POS_W : 7;

    logic [7:0]       grid_size_reg;
    logic [POS_W-1:0] row_pos_reg, col_pos_reg;
    logic [POS_W-1:0] row_pos_next, col_pos_next;

    logic             clr_busy_reg;
    logic [POS_W-1:0] clr_addr_reg;

    line_state_t      col_mem [MAX_SIDE];
    line_state_t      col_rd_reg;
    logic             fwd_hit_reg;
    line_state_t      fwd_data_reg;

    logic             s1_valid_reg;
    logic             s1_filled_reg;
    logic [POS_W-1:0] s1_r_reg, s1_c_reg;
    logic             s1_row_end_reg, s1_col_end_reg;
    line_state_t      row_st_reg;

    logic [CMP_W-1:0]  gs_ext, side_cmp;
    logic [SIDE_W-1:0] side, side_m1;
    logic [SIDE_W-1:0] c_inc, r_inc;
    logic [POS_W-1:0]  r_eff, c_eff;
    logic              row_end, col_end;
    logic              accept;

    line_state_t      row_cur, col_cur;
    line_out_t        row_o, col_o;
    push_t            push;
    logic [2:0]       s1_n;
    logic             mem_wr_en;
    logic [POS_W-1:0] mem_wr_addr;
    line_state_t      mem_wr_data;

    result_t             q_head;
    logic [OQ_CNT_W-1:0] q_level;

    // Effective side, clamped to 1..MAX_SIDE, and the position of this cell.
    always_comb begin
        gs_ext = CMP_W'(grid_size_reg);
        if (grid_size_reg == 8'd0) begin
            side_cmp = CMP_W'(1);
        end else if (gs_ext > CMP_W'(MAX_SIDE)) begin
            side_cmp = CMP_W'(MAX_SIDE);
        end else begin
            side_cmp = gs_ext;
        end
        side = SIDE_W'(side_cmp);
        side_m1 = side - SIDE_W'(1);
        if (SIDE_W'(row_pos_reg) >= side || SIDE_W'(col_pos_reg) >= side) begin
            r_eff = '0;
            c_eff = '0;
        end else begin
            r_eff = row_pos_reg;
            c_eff = col_pos_reg;
        end
        row_end = (SIDE_W'(c_eff) == side_m1);
        col_end = (SIDE_W'(r_eff) == side_m1);
        c_inc = SIDE_W'(c_eff) + SIDE_W'(1);
        r_inc = SIDE_W'(r_eff) + SIDE_W'(1);
        row_pos_next = r_eff;
        col_pos_next = POS_W'(c_inc);
        if (c_inc >= side) begin
            col_pos_next = '0;
            row_pos_next = (r_inc >= side) ? '0 : POS_W'(r_inc);
        end
    end

    // Second stage: both line updates for the cell read last cycle.
    always_comb begin
        row_cur = (s1_c_reg == '0) ? '0 : row_st_reg;
        if (s1_r_reg == '0) begin
            col_cur = '0;
        end else if (fwd_hit_reg) begin
            col_cur = fwd_data_reg;
        end else begin
            col_cur = col_rd_reg;
        end
        row_o = line_step(s1_filled_reg, s1_row_end_reg, row_cur);
        col_o = line_step(s1_filled_reg, s1_col_end_reg, col_cur);

        push.valid = {col_o.emit_last, col_o.emit_a, row_o.emit_last, row_o.emit_a}
                     & {RES_PER_ITEM{s1_valid_reg}};
        push.res[0] = '{1'b0, 7'(IDX_W'(s1_r_reg)), row_o.len_a, 1'b0};
        push.res[1] = '{1'b0, 7'(IDX_W'(s1_r_reg)), row_o.len_last, 1'b1};
        push.res[2] = '{1'b1, 7'(IDX_W'(s1_c_reg)), col_o.len_a, 1'b0};
        push.res[3] = '{1'b1, 7'(IDX_W'(s1_c_reg)), col_o.len_last, 1'b1};
        s1_n = 3'($countones(push.valid));

        mem_wr_en = clr_busy_reg || s1_valid_reg;
        mem_wr_addr = clr_busy_reg ? clr_addr_reg : s1_c_reg;
        mem_wr_data = clr_busy_reg ? '0 : col_o.next_st;
    end

    assign s_ready = !clr_busy_reg
                     && ((q_level + OQ_CNT_W'(s1_n)) <= OQ_CNT_W'(OQ_DEPTH - RES_PER_ITEM));
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            col_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (accept) begin
            col_rd_reg <= col_mem[c_eff];
            fwd_data_reg <= col_o.next_st;
            s1_filled_reg <= s_cell_filled;
            s1_r_reg <= r_eff;
            s1_c_reg <= c_eff;
            s1_row_end_reg <= row_end;
            s1_col_end_reg <= col_end;
        end
        if (s1_valid_reg) begin
            row_st_reg <= row_o.next_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RESET;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                grid_size_reg <= cfg_wr_data;
            end
            if (clr_busy_reg) begin
                if (clr_addr_reg == POS_W'(MAX_SIDE - 1)) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + POS_W'(1);
                end
            end
            s1_valid_reg <= accept;
            if (accept) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
                // The write-back of the cell in stage two lands on this edge,
                // after the read has sampled the old entry.
                fwd_hit_reg <= s1_valid_reg && (s1_c_reg == c_eff);
            end
        end
    end

    rclp_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (m_valid && m_ready),
        .head    (q_head),
        .level   (q_level)
    );

    assign m_valid = (q_level != '0);
    assign m_is_column = q_head.is_column;
    assign m_line_index = q_head.line_index;
    assign m_run_length = q_head.run_length;
    assign m_last_in_line = q_head.last_in_line;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready)
        else $error("request accepted during memory clearing");

    a_stage_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted request did not reach stage two");

    a_bypass_only_same_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && fwd_hit_reg) |-> ($past(s1_valid_reg) && $past(s1_c_reg) == s1_c_reg))
        else $error("bypass taken for a different column");
`endif

endmodule

/* sv/rclp_out_fifo.sv */
`timescale 1ns / 1ps
// Result queue that takes up to four results per cycle and gives one.
// Depends on rclp_pkg.
module rclp_out_fifo
    import rclp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  push_t               push,
    input  logic                pop,
    output result_t             head,
    output logic [OQ_CNT_W-1:0] level
);

    result_t               entries [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_CNT_W-1:0]   level_reg, level_next;
    logic [OQ_PTR_W-1:0]   offs [RES_PER_ITEM];
    logic [OQ_PTR_W-1:0]   n_push;

    // Valid results are packed together in their original order.
    always_comb begin
        offs[0] = '0;
        for (int k = 1; k < RES_PER_ITEM; k++) begin
            offs[k] = offs[k-1] + OQ_PTR_W'(push.valid[k-1]);
        end
        n_push = offs[RES_PER_ITEM-1] + OQ_PTR_W'(push.valid[RES_PER_ITEM-1]);
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
        level_next = level_reg + OQ_CNT_W'(n_push) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < RES_PER_ITEM; k++) begin
            if (push.valid[k]) begin
                entries[wr_ptr_reg + offs[k]] <= push.res[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            level_reg <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            level_reg <= level_next;
        end
    end

    assign head = entries[rd_ptr_reg];
    assign level = level_reg;

endmodule
